// ----- rtl/core/weighted_move_to_front_stack_top_macros.svh -----
// Assertion macros for the weighted move-to-front stack.
// They are active in simulation and empty in synthesis.
// The enclosing module must have clk_i and rst_ni.
`ifndef WEIGHTED_MOVE_TO_FRONT_STACK_TOP_MACROS_SVH
`define WEIGHTED_MOVE_TO_FRONT_STACK_TOP_MACROS_SVH

`ifndef SYNTHESIS

// The condition holds in the same cycle as the trigger.
`define WMTF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The condition holds in the cycle after the trigger.
`define WMTF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define WMTF_ASSERT_IMP(lbl, ante, cons, msg)
`define WMTF_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ----- rtl/core/wmtf_pkg.sv -----
package wmtf_pkg;

  // Sizes of the stack and the weight table.
  localparam int NUM_ITEMS   = 512;
  localparam int WEIGHT_BITS = 16;
  localparam int IDX_W       = $clog2(NUM_ITEMS);

  // Fixed field widths.
  localparam int ID_W    = 9;
  localparam int WIN_W   = 16;
  localparam int COST_W  = 25;
  localparam int TOTAL_W = 48;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_REQ  = 1'b1
  } op_e;

  // An item as it travels down the row of cells. For a load, id and wt are
  // the target and its new weight. For a request, id is the target, while
  // cid and wt are the entry being pushed down the stack.
  typedef struct packed {
    logic                   valid;
    op_e                    op;
    logic                   done;
    logic [ID_W-1:0]        id;
    logic [ID_W-1:0]        cid;
    logic [WEIGHT_BITS-1:0] wt;
    logic [COST_W-1:0]      cost;
  } tok_t;

endpackage

// ----- rtl/core/wmtf_cell.sv -----
module wmtf_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  wmtf_pkg::tok_t tok_i,
  output wmtf_pkg::tok_t tok_o,
  output logic          occ_o
);
  import wmtf_pkg::*;

  logic                   occ_q, occ_d;
  logic [ID_W-1:0]        id_q, id_d;
  logic [WEIGHT_BITS-1:0] wt_q, wt_d;
  tok_t                   tok_q, tok_d;
  logic                   match;
  logic [COST_W:0]        cost_sum;

  assign match    = occ_q && (id_q == tok_i.id);
  assign cost_sum = {1'b0, tok_i.cost} + (COST_W+1)'(wt_q);

  // One stack entry: a load refreshes the weight of a matching entry, a
  // request swaps its carried entry with this one until it finds its target
  // or an empty place.
  always_comb begin
    occ_d = occ_q;
    id_d  = id_q;
    wt_d  = wt_q;
    tok_d = tok_i;
    if (tok_i.valid) begin
      case (tok_i.op)
        OP_LOAD: begin
          if (match) begin
            wt_d = tok_i.wt;
          end
        end
        OP_REQ: begin
          if (!tok_i.done) begin
            id_d  = tok_i.cid;
            wt_d  = tok_i.wt;
            occ_d = 1'b1;
            if (match || !occ_q) begin
              tok_d.done = 1'b1;
            end else begin
              tok_d.cid  = id_q;
              tok_d.wt   = wt_q;
              tok_d.cost = cost_sum[COST_W] ? {COST_W{1'b1}} : cost_sum[COST_W-1:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Occupancy and the outgoing item are control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
      tok_q <= '0;
    end else if (adv_i) begin
      occ_q <= occ_d;
      tok_q <= tok_d;
    end
  end

  // The stored id and weight need no reset.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      id_q <= id_d;
      wt_q <= wt_d;
    end
  end

  assign tok_o = tok_q;
  assign occ_o = occ_q;

endmodule

// ----- rtl/core/wmtf_entry.sv -----
module wmtf_entry (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       operation_i,
  input  logic [wmtf_pkg::ID_W-1:0]  item_id_i,
  input  logic [wmtf_pkg::WIN_W-1:0] item_weight_i,
  output wmtf_pkg::tok_t             tok_o
);
  import wmtf_pkg::*;

  logic [WEIGHT_BITS-1:0] mem [NUM_ITEMS];
  logic [WEIGHT_BITS-1:0] rd_q;
  logic                   clr_busy_q;
  logic [IDX_W-1:0]       clr_idx_q;
  tok_t                   ent_q, ent_d;
  logic                   acc;
  logic                   in_range;
  logic [IDX_W-1:0]       addr;

  assign in_stall_o = clr_busy_q || !adv_i;
  assign acc        = in_valid_i && !in_stall_o;
  assign in_range   = 32'(item_id_i) < 32'(NUM_ITEMS);
  assign addr       = IDX_W'(item_id_i);

  // Clearing pass over the weight table after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clr_busy_q) begin
      clr_idx_q <= clr_idx_q + 1'b1;
      if (clr_idx_q == IDX_W'(NUM_ITEMS - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // Weight table: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_idx_q] <= '0;
    end else if (acc && (operation_i == OP_LOAD) && in_range) begin
      mem[addr] <= item_weight_i[WEIGHT_BITS-1:0];
    end
    if (acc) begin
      rd_q <= mem[addr];
    end
  end

  // Build the item that enters the first cell. An id beyond the table is
  // finished at once, so a request for it costs nothing and moves nothing.
  always_comb begin
    ent_d       = '0;
    ent_d.valid = acc && ((operation_i == OP_REQ) || in_range);
    ent_d.op    = op_e'(operation_i);
    ent_d.done  = !in_range;
    ent_d.id    = item_id_i;
    ent_d.cid   = item_id_i;
    ent_d.wt    = item_weight_i[WEIGHT_BITS-1:0];
    ent_d.cost  = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else if (adv_i) begin
      ent_q <= ent_d;
    end
  end

  // A request carries the weight just read from the table.
  always_comb begin
    tok_o = ent_q;
    if (ent_q.op == OP_REQ) begin
      tok_o.wt = rd_q;
    end
  end

endmodule

// ----- rtl/core/weighted_move_to_front_stack_top.sv -----
// Channel | Handshake                 | Fields
// input   | in_valid_i / in_stall_o   | operation_i, item_id_i, item_weight_i
// output  | out_valid_o / out_stall_i | request_cost_o, running_total_o
//
// An item can be accepted in every cycle while in_stall_o is low. It is taken into the entry
// register and then moves one cell per cycle while the row advances; a request's result is
// registered in the output register after it leaves the last cell. A load gives no result.
// After reset the weight table is cleared entry by entry, with in_stall_o held high.
// While a result waits under out_stall_i the whole row holds still and the input is stalled.
`include "weighted_move_to_front_stack_top_macros.svh"

module weighted_move_to_front_stack_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         operation_i,
  input  logic [wmtf_pkg::ID_W-1:0]    item_id_i,
  input  logic [wmtf_pkg::WIN_W-1:0]   item_weight_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [wmtf_pkg::COST_W-1:0]  request_cost_o,
  output logic [wmtf_pkg::TOTAL_W-1:0] running_total_o
);
  import wmtf_pkg::*;

  tok_t                 tok [NUM_ITEMS+1];
  logic [NUM_ITEMS-1:0] occ_vec;
  logic                 adv;
  logic                 out_valid_q;
  logic [COST_W-1:0]    cost_q;
  logic [TOTAL_W-1:0]   total_q;
  logic [TOTAL_W:0]     total_sum;
  logic                 res_exit;

  // The row advances unless a finished result is held back.
  assign adv = !(out_valid_q && out_stall_i);

  wmtf_entry u_entry (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .item_id_i     (item_id_i),
    .item_weight_i (item_weight_i),
    .tok_o         (tok[0])
  );

  // The stack itself: entry 0 is the top.
  for (genvar k = 0; k < NUM_ITEMS; k++) begin : g_cell
    wmtf_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .tok_i  (tok[k]),
      .tok_o  (tok[k+1]),
      .occ_o  (occ_vec[k])
    );
  end

  assign res_exit  = tok[NUM_ITEMS].valid && (tok[NUM_ITEMS].op == OP_REQ);
  assign total_sum = {1'b0, total_q} + (TOTAL_W+1)'(tok[NUM_ITEMS].cost);

  // Output register and the saturating running total.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      total_q     <= '0;
    end else if (adv) begin
      out_valid_q <= res_exit;
      if (res_exit) begin
        total_q <= total_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : total_sum[TOTAL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res_exit) begin
      cost_q <= tok[NUM_ITEMS].cost;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign request_cost_o  = cost_q;
  assign running_total_o = total_q;

  // Occupied entries always form an unbroken run from the top.
  `WMTF_ASSERT_IMP(a_occ_prefix, 1'b1, ((occ_vec >> 1) & ~occ_vec) == '0, "stack has a gap")
  // The running total never goes down.
  `WMTF_ASSERT_NXT(a_total_mono, 1'b1, total_q >= $past(total_q), "running total decreased")
  // A new result appears only after a request leaves the last cell.
  `WMTF_ASSERT_IMP(a_out_src, $rose(out_valid_q), $past(res_exit), "result without request")

endmodule
